// ===== hw/rtl/sha1md_pkg.sv =====
// Package for the SHA-1 message digest block: shared types and constants.
// Used by the front packer, the queue, the compression core and the top level.
`default_nettype none
package sha1md_pkg;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // One command from the front to the back: a full 512-bit block and
    // whether the digest is to be emitted after it is compressed.
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } blk_cmd_t;

    typedef enum logic [1:0] {
        FR_TAKE,
        FR_PAD1,
        FR_PAD2
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } back_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha1md_front.sv =====
// Front part: packs message bytes big-endian into 64-byte blocks, counts
// the length, and builds the padding blocks. Depends on sha1md_pkg.
`default_nettype none
module sha1md_front
    import sha1md_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       valid,
    output logic            stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       byte_valid,
    input  wire logic       end_of_message,
    output logic            cmd_valid,
    input  wire logic       cmd_stall,
    output blk_cmd_t        cmd
);

    front_state_t state_reg, state_next;
    logic [7:0]  buf_reg [64];
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] len_reg, len_next;
    logic        cmd_valid_reg, cmd_valid_next;
    blk_cmd_t    cmd_reg, cmd_next;
    // Byte position where the pad byte sits; needed by the padding states.
    logic [5:0]  padpos_reg, padpos_next;

    logic        out_free;
    logic        accept;
    logic [63:0] bits;
    logic [511:0] packed_buf;

    assign out_free = !cmd_valid_reg || !cmd_stall;
    assign stall    = (state_reg != FR_TAKE) || !out_free;
    assign accept   = valid && !stall;
    assign bits     = {len_reg, 3'b000};

    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            packed_buf[511 - 8*i -: 8] = buf_reg[i];
        end
    end

    always_comb
    begin
        logic [511:0] blk;
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        padpos_next    = padpos_reg;
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && cmd_stall;
        blk            = packed_buf;
        unique case (state_reg)
            FR_TAKE:
            begin
                if (accept)
                begin
                    if (byte_valid)
                    begin
                        len_next  = len_reg + 61'd1;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            blk[7:0]       = data_byte;
                            cmd_next.block = blk;
                            cmd_next.final_blk = 1'b0;
                            cmd_valid_next = 1'b1;
                        end
                    end
                    if (end_of_message)
                    begin
                        padpos_next = byte_valid ? fill_reg + 6'd1 : fill_reg;
                        state_next  = FR_PAD1;
                    end
                end
            end
            FR_PAD1:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < 64; i++)
                    begin
                        if (6'(i) == padpos_reg)
                            blk[511 - 8*i -: 8] = PAD_BYTE;
                        else if (6'(i) > padpos_reg)
                            blk[511 - 8*i -: 8] = 8'h00;
                    end
                    cmd_valid_next = 1'b1;
                    if (padpos_reg >= 6'd56)
                    begin
                        cmd_next.block     = blk;
                        cmd_next.final_blk = 1'b0;
                        state_next         = FR_PAD2;
                    end
                    else
                    begin
                        blk[63:0]          = bits;
                        cmd_next.block     = blk;
                        cmd_next.final_blk = 1'b1;
                        fill_next          = 6'd0;
                        len_next           = 61'd0;
                        state_next         = FR_TAKE;
                    end
                end
            end
            FR_PAD2:
            begin
                if (out_free)
                begin
                    cmd_next.block     = {448'd0, bits};
                    cmd_next.final_blk = 1'b1;
                    cmd_valid_next     = 1'b1;
                    fill_next          = 6'd0;
                    len_next           = 61'd0;
                    state_next         = FR_TAKE;
                end
            end
            default:
            begin
                state_next = FR_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FR_TAKE;
            fill_reg      <= 6'd0;
            len_reg       <= 61'd0;
            cmd_valid_reg <= 1'b0;
            padpos_reg    <= 6'd0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            cmd_valid_reg <= cmd_valid_next;
            padpos_reg    <= padpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (accept && byte_valid)
            buf_reg[fill_reg] <= data_byte;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    property p_pad_blocks_stall;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != FR_TAKE) |-> stall;
    endproperty
    a_pad_blocks_stall: assert property (p_pad_blocks_stall)
        else $error("front accepted an item while padding");

    property p_end_clears_len;
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid_next && cmd_next.final_blk && !(cmd_valid_reg && cmd_stall))
            |=> (len_reg == 61'd0 && fill_reg == 6'd0);
    endproperty
    a_end_clears_len: assert property (p_end_clears_len)
        else $error("length not cleared after final block");

    property p_pad2_after_pad1;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == FR_PAD2) |-> ($past(state_reg) == FR_PAD1 || $past(state_reg) == FR_PAD2);
    endproperty
    a_pad2_after_pad1: assert property (p_pad2_after_pad1)
        else $error("second pad block without first");

endmodule
`default_nettype wire

// ===== hw/rtl/sha1md_queue.sv =====
// Two-entry queue of block commands between the front and the back.
// Depends on sha1md_pkg.
`default_nettype none
module sha1md_queue
    import sha1md_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire blk_cmd_t in_cmd,
    output logic          out_valid,
    input  wire logic     out_stall,
    output blk_cmd_t      out_cmd
);

    blk_cmd_t  mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_cmd   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_cmd;
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue count out of range");

    property p_count_track;
        @(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1);
    endproperty
    a_count_track: assert property (p_count_track)
        else $error("queue count did not follow push");

    property p_ptr_gap;
        @(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wp_reg != rp_reg);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap)
        else $error("queue pointers inconsistent");

endmodule
`default_nettype wire

// ===== hw/rtl/sha1md_core.sv =====
// Back part: 80-round SHA-1 compression, one round per cycle, with the
// chaining words and the digest output register. Depends on sha1md_pkg.
`default_nettype none
module sha1md_core
    import sha1md_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire blk_cmd_t   cmd,
    output logic            valid,
    input  wire logic       stall,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word
);

    back_state_t state_reg, state_next;
    logic [31:0] h_reg [5];
    logic [31:0] v_reg [5];
    logic [31:0] w_reg [16];
    logic [6:0]  rnd_reg;
    logic        fin_reg;
    logic [2:0]  idx_reg;
    logic        oval_reg;
    logic [31:0] oword_reg;
    logic [2:0]  oidx_reg;

    logic        take, ofree;
    logic [31:0] w_new, w_cur, f, k, tmp;

    assign cmd_stall = (state_reg != BK_IDLE);
    assign take      = cmd_valid && !cmd_stall;
    assign ofree     = !oval_reg || !stall;

    // w_cur is w_reg[0] in rounds 0-15, then w_new; the window shifts.
    assign w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 5'd1);
    assign w_cur = (rnd_reg < 7'd16) ? w_reg[0] : w_new;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k = K2;
        end
        else
        begin
            f = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k = K3;
        end
    end

    assign tmp = rotl(v_reg[0], 5'd5) + f + v_reg[4] + w_cur + k;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (take) state_next = BK_ROUND;
            BK_ROUND: if (rnd_reg == 7'd79) state_next = BK_ADD;
            BK_ADD:   state_next = fin_reg ? BK_OUT : BK_IDLE;
            BK_OUT:   if (ofree && idx_reg == 3'd4) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            h_reg[0]  <= H0;
            h_reg[1]  <= H1;
            h_reg[2]  <= H2;
            h_reg[3]  <= H3;
            h_reg[4]  <= H4;
            rnd_reg   <= 7'd0;
            idx_reg   <= 3'd0;
            oval_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_OUT && ofree)
                oval_reg <= 1'b1;
            else if (oval_reg && !stall)
                oval_reg <= 1'b0;
            unique case (state_reg)
                BK_IDLE:
                begin
                    rnd_reg <= 7'd0;
                    if (take)
                        fin_reg <= cmd.final_blk;
                end
                BK_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                end
                BK_ADD:
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    idx_reg <= 3'd0;
                end
                BK_OUT:
                begin
                    if (ofree)
                    begin
                        idx_reg  <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4)
                        begin
                            h_reg[0] <= H0;
                            h_reg[1] <= H1;
                            h_reg[2] <= H2;
                            h_reg[3] <= H3;
                            h_reg[4] <= H4;
                        end
                    end
                end
                default:
                begin
                    rnd_reg <= 7'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && take)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= cmd.block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 5; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == BK_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
            v_reg[4]  <= v_reg[3];
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= rotl(v_reg[1], 5'd30);
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= tmp;
        end
        if (state_reg == BK_OUT && ofree)
        begin
            oword_reg <= h_reg[idx_reg];
            oidx_reg  <= idx_reg;
        end
    end

    assign valid       = oval_reg;
    assign digest_word = oword_reg;
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd4);

    property p_round_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ROUND) |-> (rnd_reg < 7'd80);
    endproperty
    a_round_range: assert property (p_round_range)
        else $error("round counter out of range");

    property p_add_after_79;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ADD) |-> ($past(rnd_reg) == 7'd79);
    endproperty
    a_add_after_79: assert property (p_add_after_79)
        else $error("chaining add before the last round");

    property p_out_index;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT) |-> (idx_reg <= 3'd4);
    endproperty
    a_out_index: assert property (p_out_index)
        else $error("digest word index out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/sha1_message_digest.sv =====
// SHA-1 message digest top level: front packer, block queue and
// compression core. Depends on sha1md_pkg, sha1md_front, sha1md_queue, sha1md_core.
//
// Message bytes enter one item per cycle while in_stall is low and are
// packed into 64-byte blocks; each full block is queued and compressed
// (a load, then 80 rounds of the single round unit, then one chaining add),
// so long messages are limited by the round unit, with input stalling once
// two blocks sit in the queue and the front holds a third. An end-of-message
// item adds one or two padding blocks and then the five digest words leave
// one per cycle while out_stall is low, word_index 0 to 4, last_word on the
// fifth.
`default_nettype none
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    logic     f_valid, f_stall, q_valid, q_stall;
    blk_cmd_t f_cmd, q_cmd;

    sha1md_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid          (in_valid),
        .stall          (in_stall),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .cmd_valid      (f_valid),
        .cmd_stall      (f_stall),
        .cmd            (f_cmd)
    );

    sha1md_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_stall (q_stall),
        .out_cmd   (q_cmd)
    );

    sha1md_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_stall   (q_stall),
        .cmd         (q_cmd),
        .valid       (out_valid),
        .stall       (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
`default_nettype wire

// ===== test/sha1_message_digest_tb.sv =====
// Testbench for sha1_message_digest: drives byte items, predicts digests
// with its own SHA-1 computation, and checks every digest word in order.
// Depends on the RTL top level sha1_message_digest and its package sha1md_pkg.
`default_nettype none
module sha1_message_digest_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha1md_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    class digest_scoreboard;
        logic [31:0] chain [5];
        logic [31:0] sched [16];
        logic [5:0]  fill;
        logic [60:0] msg_len;
        digest_item_t pending [$];
        int errors;
        int digests_seen;

        function void clear_chain();
            chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
            fill = '0;
            msg_len = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void place_byte(logic [5:0] pos, logic [7:0] b);
            int sh;
            sh = 24 - 8 * pos[1:0];
            if (pos[1:0] == 2'd0)
                sched[pos[5:2]] = 32'(b) << sh;
            else
                sched[pos[5:2]] |= 32'(b) << sh;
        endfunction

        function void fold_block();
            logic [31:0] v [5];
            logic [31:0] f, k, tmp;
            for (int i = 0; i < 5; i++)
                v[i] = chain[i];
            for (int t = 0; t < 80; t++)
            begin
                if (t >= 16)
                    sched[t % 16] = rol(sched[(t + 13) % 16] ^ sched[(t + 8) % 16]
                                        ^ sched[(t + 2) % 16] ^ sched[t % 16], 1);
                if (t < 20)
                begin
                    f = (v[1] & v[2]) | (~v[1] & v[3]); k = K0;
                end
                else if (t < 40)
                begin
                    f = v[1] ^ v[2] ^ v[3]; k = K1;
                end
                else if (t < 60)
                begin
                    f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]); k = K2;
                end
                else
                begin
                    f = v[1] ^ v[2] ^ v[3]; k = K3;
                end
                tmp = rol(v[0], 5) + f + v[4] + sched[t % 16] + k;
                v[4] = v[3]; v[3] = v[2]; v[2] = rol(v[1], 30); v[1] = v[0]; v[0] = tmp;
            end
            for (int i = 0; i < 5; i++)
                chain[i] += v[i];
        endfunction

        function void note_input(logic [7:0] b, logic bv, logic eom);
            logic [63:0] bits;
            int w;
            digest_item_t d;
            if (bv)
            begin
                place_byte(fill, b);
                msg_len++;
                fill++;
                if (fill == 0)
                    fold_block();
            end
            if (!eom)
                return;
            place_byte(fill, PAD_BYTE);
            w = fill / 4 + 1;
            if (fill >= 56)
            begin
                for (int i = w; i < 16; i++)
                    sched[i] = '0;
                fold_block();
                w = 0;
            end
            for (int i = w; i < 14; i++)
                sched[i] = '0;
            bits = {msg_len, 3'b000};
            sched[14] = bits[63:32];
            sched[15] = bits[31:0];
            fold_block();
            for (int i = 0; i < 5; i++)
            begin
                d.word = chain[i]; d.index = 3'(i); d.last = (i == 4);
                pending.push_back(d);
            end
            clear_chain();
        endfunction

        function void check_result(logic [31:0] word, logic [2:0] index, logic last);
            digest_item_t d;
            if (pending.size() == 0)
            begin
                $error("digest word with nothing expected: %h", word);
                errors++;
                return;
            end
            d = pending.pop_front();
            if (d.last)
                digests_seen++;
            if (word !== d.word)
            begin
                $error("digest_word expected %h actual %h", d.word, word);
                errors++;
            end
            if (index !== d.index)
            begin
                $error("word_index expected %0d actual %0d", d.index, index);
                errors++;
            end
            if (last !== d.last)
            begin
                $error("last_word expected %0b actual %0b", d.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard digests = new();
    int  items_sent;
    int  idle_cycles;
    bit  quiet_run;
    bit  hold_receiver;

    sha1_message_digest dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .byte_valid(byte_valid), .end_of_message(end_of_message),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one item, with a random idle gap first unless quiet_run is set, and returns once it is taken.
    task automatic send_item(logic [7:0] b, logic bv, logic eom);
        while (!quiet_run && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        byte_valid <= bv;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        digests.note_input(b, bv, eom);
        items_sent++;
    endtask

    task automatic send_message(int len, bit empty_end);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
        if (empty_end || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Results are sampled at the edge where they are accepted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            digests.check_result(digest_word, word_index, last_word);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_receiver || (!quiet_run && $urandom_range(99) < 7);
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver holds off long enough for the queue to fill and the
    // input to stall while the sender keeps offering items.
    initial
    begin
        hold_receiver = 1'b1;
        #1;
        repeat (2000) @(posedge clk);
        hold_receiver = 1'b0;
    end

    initial
    begin
        int len;
        idle_cycles = 0;
        digests.clear_chain();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short messages while the receiver is held off so the queue backs up.
        send_message(8, 1'b0);
        send_message(3, 1'b0);
        // Empty message, boundary lengths, pad spilling into a second block.
        send_message(0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_message(1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(64, 1'b0);
        send_message(64, 1'b1);
        send_message(63, 1'b1);

        quiet_run = 1'b1;
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(1, 12), $urandom_range(1));
        quiet_run = 1'b0;
        while (items_sent < 320)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
            if ($urandom_range(5) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_message(len, $urandom_range(3) == 0);
        end
        in_valid <= 1'b0;

        while (digests.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d items; %0d digests checked, including empty and block-boundary messages.",
                 items_sent, digests.digests_seen);
        if (digests.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
